[design/pe_pkg.sv]
// Shared types, constants and saturation helpers for the polynomial evaluator.
package pe_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CSR_IDX_W = 4;

   typedef logic signed [31:0] coef_type;
   typedef logic signed [47:0] sum_type;
   typedef logic signed [63:0] prod_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam coef_type ONE_Q16 = 32'sh0001_0000;
   localparam coef_type POW_MAX = 32'sh7FFF_FFFF;
   localparam coef_type POW_MIN = 32'sh8000_0000;
   localparam sum_type SUM_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam sum_type SUM_MIN = 48'sh8000_0000_0000;

   // One partial evaluation as it travels down the chain.
   typedef struct packed {
      coef_type x;
      coef_type pw;
      sum_type sum;
      logic flag;
   } word_type;

   // Forward half of a handshake between two neighboring stages.
   typedef struct packed {
      logic valid;
      word_type data;
   } link_type;

   // The product shifted right by the fraction width does not fit in 32 bits.
   function automatic logic pow_ovf(input prod_type p);
      pow_ovf = !((&p[63:47]) || !(|p[63:47]));
   endfunction

   // Product shifted right by the fraction width, clamped to 32 bits.
   function automatic coef_type pow_sat(input prod_type p);
      if (pow_ovf(p)) begin
         pow_sat = p[63] ? POW_MIN : POW_MAX;
      end else begin
         pow_sat = p[47:16];
      end
   endfunction

   // A 48-bit signed addition overflows.
   function automatic logic add_ovf(input sum_type a, input sum_type b);
      logic signed [48:0] s;
      s = {a[47], a} + {b[47], b};
      add_ovf = s[48] != s[47];
   endfunction

   // 48-bit signed addition with clamping.
   function automatic sum_type add_sat(input sum_type a, input sum_type b);
      logic signed [48:0] s;
      s = {a[47], a} + {b[47], b};
      if (s[48] != s[47]) begin
         add_sat = s[48] ? SUM_MIN : SUM_MAX;
      end else begin
         add_sat = s[47:0];
      end
   endfunction

endpackage

[design/pe_if.sv]
// Channel interfaces of the polynomial evaluator: sample, result and register write.
interface pe_req_if;
   import pe_pkg::*;
   logic valid;
   logic ready;
   coef_type x_value;
   modport source (output valid, output x_value, input ready);
   modport sink (input valid, input x_value, output ready);
endinterface

interface pe_rsp_if;
   import pe_pkg::*;
   logic valid;
   logic ready;
   sum_type poly_value;
   logic saturated;
   modport source (output valid, output poly_value, output saturated, input ready);
   modport sink (input valid, input poly_value, input saturated, output ready);
endinterface

interface pe_csr_if;
   import pe_pkg::*;
   logic valid;
   logic ready;
   csr_idx_type index;
   coef_type data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[design/pe_cell.sv]
// One term cell: next power of x, the coefficient product and the running sum.
module pe_cell (
   input logic clock,
   input logic reset,
   input pe_pkg::coef_type coef,
   input pe_pkg::link_type up_link,
   output logic up_ready,
   output pe_pkg::link_type down_link,
   input logic down_ready
);
   import pe_pkg::*;

   // Stage 1: power times x.
   logic v1_ff;
   coef_type x1_ff;
   sum_type sum1_ff;
   logic flag1_ff;
   prod_type pa1_ff;
   prod_type pa1_in;

   // Stage 2: clamped power, coefficient times power.
   logic v2_ff;
   coef_type x2_ff;
   coef_type pw2_ff;
   sum_type sum2_ff;
   logic flag2_ff;
   prod_type pb2_ff;
   coef_type pw2_in;
   logic flag2_in;
   prod_type pb2_in;

   // Stage 3: term added into the running sum.
   link_type link3_ff;
   sum_type term;
   link_type link3_in;

   logic rdy1;
   logic rdy2;
   logic rdy3;

   // A stage may load when it is empty or its content moves on.
   assign rdy3 = !link3_ff.valid || down_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign up_ready = rdy1;

   assign pa1_in = up_link.data.pw * up_link.data.x;

   assign pw2_in = pow_sat(pa1_ff);
   assign flag2_in = flag1_ff | pow_ovf(pa1_ff);
   assign pb2_in = coef * pw2_in;

   // The shifted product of two 32-bit values always fits in 48 bits.
   assign term = pb2_ff[63:16];

   always_comb begin
      link3_in.valid = v2_ff;
      link3_in.data.x = x2_ff;
      link3_in.data.pw = pw2_ff;
      link3_in.data.sum = add_sat(sum2_ff, term);
      link3_in.data.flag = flag2_ff | add_ovf(sum2_ff, term);
   end

   // Valid bits and payload of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         link3_ff.valid <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= up_link.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) link3_ff.valid <= link3_in.valid;
      end
      if (rdy1 && up_link.valid) begin
         x1_ff <= up_link.data.x;
         sum1_ff <= up_link.data.sum;
         flag1_ff <= up_link.data.flag;
         pa1_ff <= pa1_in;
      end
      if (rdy2 && v1_ff) begin
         x2_ff <= x1_ff;
         pw2_ff <= pw2_in;
         sum2_ff <= sum1_ff;
         flag2_ff <= flag2_in;
         pb2_ff <= pb2_in;
      end
      if (rdy3 && v2_ff) begin
         link3_ff.data <= link3_in.data;
      end
   end

   assign down_link = link3_ff;

endmodule

[design/polynomial_evaluator_unit.sv]
// Top level of the polynomial evaluator: coefficient registers and the chain of term cells.
//
// Usage: each word on req_chan carries one signed Q16.16 sample x_value. The block
// returns one word on rsp_chan per sample, in order: poly_value is the saturated
// signed Q32.16 sum of coef_i times x to the power i, and saturated flags any
// clamped power or partial sum. Coefficients are written through csr_chan, index i
// selecting coef_i; writes to indexes at or above NUM_COEFFS are dropped. csr_chan
// is always ready and should be written only while no sample is in flight.
// An entry register seeds the constant term, then each of the NUM_COEFFS - 1 cells
// holds three stages (power multiply, coefficient multiply, saturating add).
// Throughput: one sample per cycle while the receiver is ready; the two multipliers of
// each cell are the pacing units. When the receiver stalls, stages fill up from the output
// back; req_chan.ready drops only once the entry register is full and cannot move on.
// Reset clears all coefficients to zero and empties every stage.
module polynomial_evaluator_unit #(
   parameter int NUM_COEFFS = 8
) (
   input logic clock,
   input logic reset,
   pe_req_if.sink req_chan,
   pe_rsp_if.source rsp_chan,
   pe_csr_if.sink csr_chan
);
   import pe_pkg::*;

   localparam int IDX_W = $clog2(NUM_COEFFS);

   coef_type coef_ff [NUM_COEFFS];
   link_type links [NUM_COEFFS];
   logic chain_ready [NUM_COEFFS];
   link_type link0_ff;
   link_type link0_in;
   logic entry_ready;

   // Coefficient registers.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_chan.valid && (int'(csr_chan.index) < NUM_COEFFS)) begin
         coef_ff[csr_chan.index[IDX_W-1:0]] <= csr_chan.data;
      end
   end

   // Entry register: the constant term equals coef_0, the first power is one.
   always_comb begin
      link0_in.valid = req_chan.valid;
      link0_in.data.x = req_chan.x_value;
      link0_in.data.pw = ONE_Q16;
      link0_in.data.sum = sum_type'(coef_ff[0]);
      link0_in.data.flag = 1'b0;
   end

   assign entry_ready = !link0_ff.valid || chain_ready[0];
   assign req_chan.ready = entry_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         link0_ff.valid <= 1'b0;
      end else if (entry_ready) begin
         link0_ff.valid <= link0_in.valid;
      end
      if (entry_ready && req_chan.valid) begin
         link0_ff.data <= link0_in.data;
      end
   end

   assign links[0] = link0_ff;

   // One cell per term of degree one and up.
   for (genvar k = 1; k < NUM_COEFFS; k++) begin : g_cell
      pe_cell u_cell (
         .clock(clock),
         .reset(reset),
         .coef(coef_ff[k]),
         .up_link(links[k-1]),
         .up_ready(chain_ready[k-1]),
         .down_link(links[k]),
         .down_ready(chain_ready[k])
      );
   end

   // Result word comes straight from the last cell's output stage.
   assign chain_ready[NUM_COEFFS-1] = rsp_chan.ready;
   assign rsp_chan.valid = links[NUM_COEFFS-1].valid;
   assign rsp_chan.poly_value = links[NUM_COEFFS-1].data.sum;
   assign rsp_chan.saturated = links[NUM_COEFFS-1].data.flag;

   // An accepted sample lands in the entry register on the next edge.
   a_entry_load: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=>
         links[0].valid && (links[0].data.x == $past(req_chan.x_value)))
      else $error("accepted sample not captured by entry register");

   // A blocked entry register keeps its word.
   a_entry_hold: assert property (@(posedge clock) disable iff (reset)
      links[0].valid && !chain_ready[0] |=> links[0].valid && $stable(links[0].data))
      else $error("entry register lost or changed a stalled word");

   // Reset empties the output stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule
